// ===== src/sha1md_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 digest block.
package sha1md_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] chain_t;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned RoundW = $clog2(NumRounds);
  localparam int unsigned PosW = $clog2(BlockWords);

  localparam word_t PadWord = 32'h8000_0000;

  localparam word_t K0 = 32'h5a82_7999;
  localparam word_t K1 = 32'h6ed9_eba1;
  localparam word_t K2 = 32'h8f1b_bcdc;
  localparam word_t K3 = 32'hca62_c1d6;

  localparam chain_t InitChain = {32'hc3d2_e1f0, 32'h1032_5476, 32'h98ba_dcfe,
                                  32'hefcd_ab89, 32'h6745_2301};

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_DONE
  } state_e;

  // control from the sequencer to the round unit
  typedef struct packed {
    logic  push;
    word_t push_word;
    logic  load;
    logic  step;
  } ctl_t;

  // round-dependent boolean function
  function automatic word_t round_f(logic [RoundW-1:0] r, word_t b, word_t c, word_t d);
    word_t f;
    if (r < RoundW'(20)) begin
      f = (b & c) | (~b & d);
    end else if (r < RoundW'(40)) begin
      f = b ^ c ^ d;
    end else if (r < RoundW'(60)) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // round-dependent additive constant
  function automatic word_t round_k(logic [RoundW-1:0] r);
    word_t k;
    if (r < RoundW'(20)) begin
      k = K0;
    end else if (r < RoundW'(40)) begin
      k = K1;
    end else if (r < RoundW'(60)) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// ===== src/sha1md_if.sv =====
// Handshake channels of the SHA-1 digest block: message words in, digest out.
interface sha1md_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_item;

  modport source (output valid, output message_word, output valid_bytes,
                  output last_item, input ready);
  modport sink (input valid, input message_word, input valid_bytes,
                input last_item, output ready);
endinterface

interface sha1md_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_h0;
  logic [31:0] digest_h1;
  logic [31:0] digest_h2;
  logic [31:0] digest_h3;
  logic [31:0] digest_h4;

  modport source (output valid, output digest_h0, output digest_h1, output digest_h2,
                  output digest_h3, output digest_h4, input ready);
  modport sink (input valid, input digest_h0, input digest_h1, input digest_h2,
                input digest_h3, input digest_h4, output ready);
endinterface

// ===== src/sha1_message_digest.sv =====
// SHA-1 digest of a word stream: padding sequencer, chaining state and result register.
//
//   channel  dir  payload                                   handshake
//   msg_i    in   message_word, valid_bytes, last_item      valid / ready
//   dig_o    out  digest_h0 .. digest_h4                    valid / ready
//
// Each accepted message word is pushed into the round unit; a block's 16th word starts
// its 80 rounds on the single round unit, then the chaining add. The last item is
// followed by padding pushes, one or two blocks, and the load of the result.
// ready is low from a block's 16th word until its chaining add is done, and during
// padding. The digest waits in an output register; the next message streams in
// meanwhile and stalls only when its own digest is due before the old one is taken.
// Reset loads the initial chaining words and clears length, position and counters.
module sha1_message_digest (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha1md_msg_if.sink   msg_i,
  sha1md_dig_if.source dig_o
);
  import sha1md_pkg::*;

  state_e          state_q, state_d;
  chain_t          chain_q, chain_d;
  logic [63:0]     bitlen_q, bitlen_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            pad80_q, pad80_d;   // full last word: pad word still owed
  logic            lenhi_q, lenhi_d;   // upper length word already pushed
  logic            fin_q, fin_d;       // finishing a message
  logic            done_q, done_d;     // last block is in the round unit
  logic            out_valid_q, out_valid_d;
  logic            out_load;
  chain_t          digest_q;

  ctl_t            ctl;
  chain_t          work;
  logic            last_round;

  sha1md_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .chain_i     (chain_q),
    .work_o      (work),
    .last_round_o(last_round)
  );

  // sequencer
  always_comb begin
    logic [2:0] nb;
    word_t      mask;
    word_t      pad;
    state_d     = state_q;
    chain_d     = chain_q;
    bitlen_d    = bitlen_q;
    pos_d       = pos_q;
    pad80_d     = pad80_q;
    lenhi_d     = lenhi_q;
    fin_d       = fin_q;
    done_d      = done_q;
    out_load    = 1'b0;
    ctl         = '0;
    msg_i.ready = 1'b0;
    nb          = (msg_i.valid_bytes > 3'd4) ? 3'd4 : msg_i.valid_bytes;
    mask        = '0;
    pad         = PadWord;

    unique case (nb)
      3'd1: begin
        mask = 32'hff00_0000;
        pad  = 32'h0080_0000;
      end
      3'd2: begin
        mask = 32'hffff_0000;
        pad  = 32'h0000_8000;
      end
      3'd3: begin
        mask = 32'hffff_ff00;
        pad  = 32'h0000_0080;
      end
      default: begin
        mask = '0;
        pad  = PadWord;
      end
    endcase

    unique case (state_q)
      ST_IDLE: begin
        msg_i.ready = 1'b1;
        if (msg_i.valid) begin
          ctl.push = 1'b1;
          pos_d    = pos_q + PosW'(1);
          fin_d    = msg_i.last_item;
          if (!msg_i.last_item) begin
            bitlen_d      = bitlen_q + 64'd32;
            ctl.push_word = msg_i.message_word;
          end else begin
            bitlen_d = bitlen_q + {58'd0, nb, 3'd0};
            if (nb == 3'd4) begin
              ctl.push_word = msg_i.message_word;
              pad80_d       = 1'b1;
            end else begin
              ctl.push_word = (msg_i.message_word & mask) | pad;
            end
          end
          if (pos_q == PosW'(BlockWords - 1)) begin
            ctl.load = 1'b1;
            state_d  = ST_COMP;
          end else if (msg_i.last_item) begin
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        ctl.push = 1'b1;
        pos_d    = pos_q + PosW'(1);
        if (pad80_q) begin
          ctl.push_word = PadWord;
          pad80_d       = 1'b0;
        end else if (pos_q == PosW'(BlockWords - 2)) begin
          ctl.push_word = bitlen_q[63:32];
          lenhi_d       = 1'b1;
        end else if (pos_q == PosW'(BlockWords - 1) && lenhi_q) begin
          ctl.push_word = bitlen_q[31:0];
          done_d        = 1'b1;
        end else begin
          ctl.push_word = '0;
        end
        if (pos_q == PosW'(BlockWords - 1)) begin
          ctl.load = 1'b1;
          state_d  = ST_COMP;
        end
      end

      ST_COMP: begin
        ctl.step = 1'b1;
        if (last_round) begin
          state_d = ST_ADD;
        end
      end

      ST_ADD: begin
        for (int i = 0; i < 5; i++) begin
          chain_d[i] = chain_q[i] + work[i];
        end
        if (done_q) begin
          state_d = ST_DONE;
        end else if (fin_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || dig_o.ready) begin
          out_load = 1'b1;
          chain_d  = InitChain;
          bitlen_d = '0;
          pad80_d  = 1'b0;
          lenhi_d  = 1'b0;
          fin_d    = 1'b0;
          done_d   = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (dig_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chain_q     <= InitChain;
      bitlen_q    <= '0;
      pos_q       <= '0;
      pad80_q     <= 1'b0;
      lenhi_q     <= 1'b0;
      fin_q       <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      bitlen_q    <= bitlen_d;
      pos_q       <= pos_d;
      pad80_q     <= pad80_d;
      lenhi_q     <= lenhi_d;
      fin_q       <= fin_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // digest payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      digest_q <= chain_q;
    end
  end

  assign dig_o.valid     = out_valid_q;
  assign dig_o.digest_h0 = digest_q[0];
  assign dig_o.digest_h1 = digest_q[1];
  assign dig_o.digest_h2 = digest_q[2];
  assign dig_o.digest_h3 = digest_q[3];
  assign dig_o.digest_h4 = digest_q[4];

endmodule

// ===== src/sha1md_core.sv =====
// SHA-1 round unit: message schedule window, working variables, one round per cycle.
module sha1md_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1md_pkg::ctl_t   ctl_i,
  input  sha1md_pkg::chain_t chain_i,
  output sha1md_pkg::chain_t work_o,
  output logic              last_round_o
);
  import sha1md_pkg::*;

  // win_q[0] is the oldest schedule word; new words enter at the top
  word_t             win_q [BlockWords];
  chain_t            work_q;
  logic [RoundW-1:0] round_q;

  word_t  sched_x;
  word_t  t_sum;
  word_t  a, b, c, d, e;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];

  // schedule word: first 16 rounds replay the block, later ones expand it
  always_comb begin
    word_t mix;
    mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    if (round_q < RoundW'(BlockWords)) begin
      sched_x = win_q[0];
    end else begin
      sched_x = {mix[30:0], mix[31]};
    end
  end

  assign t_sum = {a[26:0], a[31:27]} + round_f(round_q, b, c, d) + e
                 + round_k(round_q) + sched_x;

  // schedule window: shifts on every pushed word and every round
  always_ff @(posedge clk_i) begin
    if (ctl_i.push || ctl_i.step) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[BlockWords-1] <= ctl_i.push ? ctl_i.push_word : sched_x;
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      work_q <= chain_i;
    end else if (ctl_i.step) begin
      work_q[4] <= d;
      work_q[3] <= c;
      work_q[2] <= {b[1:0], b[31:2]};
      work_q[1] <= a;
      work_q[0] <= t_sum;
    end
  end

  // round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q <= '0;
    end else if (ctl_i.load) begin
      round_q <= '0;
    end else if (ctl_i.step) begin
      round_q <= round_q + RoundW'(1);
    end
  end

  assign work_o       = work_q;
  assign last_round_o = (round_q == RoundW'(NumRounds - 1));

endmodule
